// ----- rtl/lfpd_pkg.sv -----
// ----------------------------------------------------------------------------
// lfpd_pkg
// Shared types and constants of the line follower PD steering block
// ----------------------------------------------------------------------------
package lfpd_pkg;

  localparam int unsigned SensorCount = 5;
  localparam int unsigned RegIdxW     = 2;
  localparam int unsigned RegW        = 8;
  localparam int unsigned DutyW       = 8;
  localparam int unsigned ErrW        = 3;
  localparam int unsigned DiffW       = 4;
  localparam int unsigned ProdW       = 13;
  localparam int unsigned SumW        = 14;

  localparam logic signed [ErrW-1:0] LostErrPos = 3'sd3;
  localparam logic signed [ErrW-1:0] LostErrNeg = -3'sd3;

  // position weight of each sensor, index 0 is the leftmost
  localparam logic signed [ErrW-1:0] SensorWeight [SensorCount] =
    '{-3'sd2, -3'sd1, 3'sd0, 3'sd1, 3'sd2};

  typedef enum logic [RegIdxW-1:0] {
    REG_PROP_GAIN  = 2'd0,
    REG_DERIV_GAIN = 2'd1,
    REG_BASE_SPEED = 2'd2,
    REG_MAX_SPEED  = 2'd3
  } lfpd_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_D,
    ST_LEFT,
    ST_RIGHT
  } lfpd_state_e;

endpackage

// ----- rtl/line_follower_pd_steering.sv -----
// ----------------------------------------------------------------------------
// line_follower_pd_steering
// An accepted sensor beat is registered, then runs MUL_P, MUL_D, LEFT and
// RIGHT on the single shared multiply/add unit (p term, d term, left and
// right duty in turn); its result is registered once the output is free.
// A new beat is taken in IDLE or as the last one leaves RIGHT. An async
// active-low reset restores gain/speed defaults and clears the previous error.
// ----------------------------------------------------------------------------
module line_follower_pd_steering (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [4:0]                         sensor_bits_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [lfpd_pkg::DutyW-1:0]         left_duty_o,
  output logic [lfpd_pkg::DutyW-1:0]         right_duty_o,
  output logic signed [lfpd_pkg::ErrW-1:0]   line_error_o,
  output logic                               line_lost_o,
  input  logic                               cfg_we_i,
  input  logic [lfpd_pkg::RegIdxW-1:0]       cfg_idx_i,
  input  logic [lfpd_pkg::RegW-1:0]          cfg_data_i
);
  import lfpd_pkg::*;

  lfpd_state_e state_q, state_d;

  logic [RegW-1:0] prop_gain_q, deriv_gain_q, base_speed_q, max_speed_q;
  logic signed [ErrW-1:0] prev_err_q, err_q, err_new;
  logic lost_q, lost_new;
  logic signed [ProdW-1:0] acc_q;
  logic [DutyW-1:0] left_tmp_q, duty_clamped;
  logic out_valid_q, out_free, in_accept;
  logic [DutyW-1:0] left_duty_q, right_duty_q;
  logic signed [ErrW-1:0] line_error_q;
  logic line_lost_q;

  // error from the sensor sample
  logic signed [ErrW-1:0] pos_sum;
  logic [2:0] act_cnt;
  logic [2:0] abs_sum;
  logic signed [ErrW-1:0] mag;

  always_comb begin
    pos_sum = '0;
    act_cnt = '0;
    for (int i = 0; i < SensorCount; i++) begin
      if (sensor_bits_i[i]) begin
        pos_sum = pos_sum + SensorWeight[i];
        act_cnt = act_cnt + 3'd1;
      end
    end
    abs_sum = pos_sum[ErrW-1] ? 3'(-pos_sum) : 3'(pos_sum);
    // truncating divide by the count: |sum| is at most 3
    if ({1'b0, abs_sum} >= {act_cnt, 1'b0}) begin
      mag = 3'sd2;
    end else if (abs_sum >= act_cnt) begin
      mag = 3'sd1;
    end else begin
      mag = 3'sd0;
    end
    if (act_cnt == 3'd0) begin
      lost_new = 1'b1;
      err_new  = (prev_err_q > 3'sd0) ? LostErrPos : LostErrNeg;
    end else begin
      lost_new = 1'b0;
      err_new  = pos_sum[ErrW-1] ? -mag : mag;
    end
  end

  // shared multiply/add unit
  logic signed [RegW:0]    mul_a;
  logic signed [DiffW-1:0] mul_b;
  logic signed [ProdW-1:0] prod;
  logic signed [SumW-1:0]  add_x, add_y, unit_sum;

  always_comb begin
    mul_a = $signed({1'b0, prop_gain_q});
    mul_b = DiffW'(err_q);
    case (state_q)
      ST_MUL_D: begin
        mul_a = $signed({1'b0, deriv_gain_q});
        mul_b = DiffW'(err_q) - DiffW'(prev_err_q);
      end
      default: ;
    endcase
    prod = mul_a * mul_b;
  end

  always_comb begin
    add_x = '0;
    add_y = SumW'(prod);
    case (state_q)
      ST_MUL_P: begin
        add_x = '0;
        add_y = SumW'(prod);
      end
      ST_MUL_D: begin
        add_x = SumW'(acc_q);
        add_y = SumW'(prod);
      end
      ST_LEFT: begin
        add_x = $signed({{(SumW-RegW){1'b0}}, base_speed_q});
        add_y = SumW'(acc_q);
      end
      ST_RIGHT: begin
        add_x = $signed({{(SumW-RegW){1'b0}}, base_speed_q});
        add_y = -SumW'(acc_q);
      end
      default: begin
        add_x = '0;
      end
    endcase
    unit_sum = add_x + add_y;
    if (unit_sum[SumW-1]) begin
      duty_clamped = '0;
    end else if (unit_sum > $signed({{(SumW-RegW){1'b0}}, max_speed_q})) begin
      duty_clamped = max_speed_q;
    end else begin
      duty_clamped = unit_sum[DutyW-1:0];
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) || (state_q == ST_RIGHT && out_free));
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_accept) state_d = ST_MUL_P;
      ST_MUL_P: state_d = ST_MUL_D;
      ST_MUL_D: state_d = ST_LEFT;
      ST_LEFT:  state_d = ST_RIGHT;
      ST_RIGHT: begin
        if (out_free) begin
          state_d = in_accept ? ST_MUL_P : ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= 8'd18;
      deriv_gain_q <= 8'd55;
      base_speed_q <= 8'd50;
      max_speed_q  <= 8'd65;
    end else if (cfg_we_i) begin
      case (lfpd_reg_e'(cfg_idx_i))
        REG_PROP_GAIN:  prop_gain_q  <= cfg_data_i;
        REG_DERIV_GAIN: deriv_gain_q <= cfg_data_i;
        REG_BASE_SPEED: base_speed_q <= cfg_data_i;
        REG_MAX_SPEED:  max_speed_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_MUL_D) begin
        prev_err_q <= err_q;
      end
      if (state_q == ST_RIGHT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      err_q  <= err_new;
      lost_q <= lost_new;
    end
    if (state_q == ST_MUL_P || state_q == ST_MUL_D) begin
      acc_q <= unit_sum[ProdW-1:0];
    end
    if (state_q == ST_LEFT) begin
      left_tmp_q <= duty_clamped;
    end
    if (state_q == ST_RIGHT && out_free) begin
      left_duty_q  <= left_tmp_q;
      right_duty_q <= duty_clamped;
      line_error_q <= err_q;
      line_lost_q  <= lost_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign left_duty_o  = left_duty_q;
  assign right_duty_o = right_duty_q;
  assign line_error_o = line_error_q;
  assign line_lost_o  = line_lost_q;

endmodule

// ----- rtl/lfpd_checker.sv -----
// ----------------------------------------------------------------------------
// lfpd_checker
// Port-level checks of the line follower PD steering block
// ----------------------------------------------------------------------------
module lfpd_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic [4:0]                         sensor_bits_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [lfpd_pkg::DutyW-1:0]         left_duty_o,
  input logic [lfpd_pkg::DutyW-1:0]         right_duty_o,
  input logic signed [lfpd_pkg::ErrW-1:0]   line_error_o,
  input logic                               line_lost_o,
  input logic                               cfg_we_i,
  input logic [lfpd_pkg::RegIdxW-1:0]       cfg_idx_i,
  input logic [lfpd_pkg::RegW-1:0]          cfg_data_i
);
  import lfpd_pkg::*;

  // a lost line reports the saturated error and only then
  a_lost_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (line_lost_o ==
      (line_error_o == LostErrPos || line_error_o == LostErrNeg)))
    else $error("line_lost does not match line_error");

  // the block is busy right after taking a sample
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("sample accepted while previous one in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result beat dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      ($stable(left_duty_o) && $stable(right_duty_o) && $stable(line_error_o)))
    else $error("stalled result beat changed");

endmodule

bind line_follower_pd_steering lfpd_checker u_lfpd_checker (.*);

// ----- bench/line_follower_pd_steering_checker.sv -----
// ----------------------------------------------------------------------------
// lfpd_steering_checker
// Watches the sensor, duty and register channels of the PD steering block,
// keeps its own copy of gains, speeds and last error, predicts every duty
// beat and compares it field by field with what the block sends out.
// ----------------------------------------------------------------------------
module lfpd_steering_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic [4:0]                           sensor_bits_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic [lfpd_pkg::DutyW-1:0]           left_duty_i,
  input  logic [lfpd_pkg::DutyW-1:0]           right_duty_i,
  input  logic signed [lfpd_pkg::ErrW-1:0]     line_error_i,
  input  logic                                 line_lost_i,
  input  logic                                 cfg_we_i,
  input  logic [lfpd_pkg::RegIdxW-1:0]         cfg_idx_i,
  input  logic [lfpd_pkg::RegW-1:0]            cfg_data_i,
  output int                                   fail_count_o,
  output int                                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import lfpd_pkg::*;

  localparam int LostMag     = 3;
  localparam int MaxReported = 40;

  typedef struct packed {
    logic [DutyW-1:0]      left;
    logic [DutyW-1:0]      right;
    logic signed [ErrW-1:0] err;
    logic                  lost;
  } steer_result_t;

  logic [RegW-1:0]        kp;
  logic [RegW-1:0]        kd;
  logic [RegW-1:0]        base_spd;
  logic [RegW-1:0]        max_spd;
  logic signed [ErrW-1:0] last_err;
  steer_result_t          steer_q[$];
  steer_result_t          oldest;
  steer_result_t          predicted;

  function automatic int limit_duty(input int duty, input int cap);
    if (duty > cap) duty = cap;
    if (duty < 0) duty = 0;
    return duty;
  endfunction

  function automatic steer_result_t predict_steering(input logic [4:0] bits);
    steer_result_t r;
    int weight_sum;
    int hits;
    int err;
    int corr;
    weight_sum = 0;
    hits = 0;
    // sensor i weighs i-2
    for (int i = 0; i < SensorCount; i++) begin
      if (bits[i]) begin
        weight_sum += i - 2;
        hits++;
      end
    end
    // int division truncates toward zero
    if (hits > 0) err = weight_sum / hits;
    else err = (last_err > 0) ? LostMag : -LostMag;
    corr = int'(kp) * err + int'(kd) * (err - int'(last_err));
    r.left  = DutyW'(limit_duty(int'(base_spd) + corr, int'(max_spd)));
    r.right = DutyW'(limit_duty(int'(base_spd) - corr, int'(max_spd)));
    r.err   = err[ErrW-1:0];
    r.lost  = (hits == 0);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count_o < MaxReported) begin
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    end
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp = 8'd18;
      kd = 8'd55;
      base_spd = 8'd50;
      max_spd = 8'd65;
      last_err = '0;
      steer_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (lfpd_reg_e'(cfg_idx_i))
          REG_PROP_GAIN:  kp = cfg_data_i;
          REG_DERIV_GAIN: kd = cfg_data_i;
          REG_BASE_SPEED: base_spd = cfg_data_i;
          REG_MAX_SPEED:  max_spd = cfg_data_i;
          default: ;
        endcase
      end
      // compare the outgoing beat before queuing a new sample
      if (out_valid_i && !out_stall_i) begin
        if (steer_q.size() == 0) begin
          report_mismatch("duty beat with no sample pending, left_duty",
                          int'(left_duty_i), 0);
        end else begin
          oldest = steer_q.pop_front();
          if (left_duty_i !== oldest.left)
            report_mismatch("left_duty", int'(left_duty_i), int'(oldest.left));
          if (right_duty_i !== oldest.right)
            report_mismatch("right_duty", int'(right_duty_i), int'(oldest.right));
          if (line_error_i !== oldest.err)
            report_mismatch("line_error", int'(line_error_i), int'(oldest.err));
          if (line_lost_i !== oldest.lost)
            report_mismatch("line_lost", int'(line_lost_i), int'(oldest.lost));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predicted = predict_steering(sensor_bits_i);
        steer_q.push_back(predicted);
        last_err = predicted.err;
      end
      pending_o = steer_q.size();
    end
  end

endmodule

// ----- bench/tb_line_follower_pd_steering.sv -----
// ----------------------------------------------------------------------------
// tb_line_follower_pd_steering
// Feeds sensor samples to the PD steering block under a series of gain and
// speed settings, with random gaps on the sensor side and random back
// pressure on the duty side; the checker beside the block predicts and
// compares every duty beat.
// ----------------------------------------------------------------------------
module tb_line_follower_pd_steering;
  timeunit 1ns;
  timeprecision 1ps;
  import lfpd_pkg::*;

  localparam int CycleLimit     = 400000;
  localparam int SettingCount   = 13;
  localparam int SamplesPerSet  = 150;
  localparam int DirectedCount  = 24;

  // single sensors, truncating averages and every kind of line loss
  localparam logic [4:0] DirectedSamples [DirectedCount] = '{
    5'b00000, 5'b00000, 5'b11111, 5'b00000, 5'b10000, 5'b00000,
    5'b00000, 5'b00001, 5'b00010, 5'b00100, 5'b01000, 5'b10000,
    5'b00011, 5'b11000, 5'b00111, 5'b11100, 5'b10011, 5'b11001,
    5'b00101, 5'b10001, 5'b01110, 5'b00000, 5'b00010, 5'b00000
  };

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [4:0]             sensor_bits;
  logic                   out_valid;
  logic                   out_stall;
  logic [DutyW-1:0]       left_duty;
  logic [DutyW-1:0]       right_duty;
  logic signed [ErrW-1:0] line_error;
  logic                   line_lost;
  logic                   cfg_we;
  logic [RegIdxW-1:0]     cfg_idx;
  logic [RegW-1:0]        cfg_data;
  int                     fail_count;
  int                     pending_beats;
  int                     cycle_count;
  int                     samples_sent;
  logic                   no_idle;

  line_follower_pd_steering dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .sensor_bits_i(sensor_bits),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .left_duty_o  (left_duty),
    .right_duty_o (right_duty),
    .line_error_o (line_error),
    .line_lost_o  (line_lost),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data)
  );

  lfpd_steering_checker steer_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .sensor_bits_i(sensor_bits),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .left_duty_i  (left_duty),
    .right_duty_i (right_duty),
    .line_error_i (line_error),
    .line_lost_i  (line_lost),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending_beats)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
        $display("timeout after %0d cycles, %0d duty beats outstanding",
                 cycle_count, pending_beats);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // duty side back pressure
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!no_idle && $urandom_range(0, 99) < 20) out_stall <= 1'b1;
      else out_stall <= 1'b0;
    end
  end

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_sample(input logic [4:0] bits);
    while (!no_idle && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sensor_bits <= bits;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    samples_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_beats != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic apply_settings(input logic [RegW-1:0] prop, input logic [RegW-1:0] deriv,
                                input logic [RegW-1:0] base, input logic [RegW-1:0] cap);
    lfpd_reg_e       reg_order [4];
    logic [RegW-1:0] reg_value [4];
    reg_order = '{REG_PROP_GAIN, REG_DERIV_GAIN, REG_BASE_SPEED, REG_MAX_SPEED};
    reg_value = '{prop, deriv, base, cap};
    for (int r = 0; r < 4; r++) begin
      cfg_we <= 1'b1;
      cfg_idx <= reg_order[r];
      cfg_data <= reg_value[r];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [4:0]      bits;
    logic [RegW-1:0] kp;
    logic [RegW-1:0] kd;
    int              mode;
    int              pos;
    in_valid = 1'b0;
    sensor_bits = '0;
    cfg_we = 1'b0;
    cfg_idx = REG_PROP_GAIN;
    cfg_data = '0;
    no_idle = 1'b0;
    samples_sent = 0;
    rst_n = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset gains and speeds first
    for (int d = 0; d < DirectedCount; d++) send_sample(DirectedSamples[d]);

    for (int p = 0; p < SettingCount; p++) begin
      if (p > 0) begin
        drain();
        case (p)
          1: apply_settings(8'd0, 8'd0, 8'd255, 8'd255);
          2: apply_settings(8'd255, 8'd255, 8'd0, 8'd0);
          3: apply_settings(8'd255, 8'd255, 8'd128, 8'd255);
          4: apply_settings(8'd1, 8'd0, 8'd100, 8'd200);
          5: apply_settings(8'd3, 8'd7, 8'd120, 8'd250);
          default: begin
            // mostly modest gains so duties are not always pinned
            kp = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 12));
            kd = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 12));
            apply_settings(kp, kd, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          end
        endcase
      end
      no_idle = (p == 6);
      for (int k = 0; k < SamplesPerSet; k++) begin
        mode = $urandom_range(0, 9);
        pos = $urandom_range(0, 4);
        if (mode < 4) begin
          bits = 5'($urandom_range(0, 31));
        end else if (mode < 8) begin
          // a line under one sensor or straddling two neighbors
          if (pos < 4 && $urandom_range(0, 1) != 0) bits = 5'b00011 << pos;
          else bits = 5'b00001 << pos;
        end else begin
          bits = 5'b00000;
        end
        send_sample(bits);
      end
    end
    drain();

    $display("covered %0d sensor samples under %0d gain and speed settings", samples_sent,
             SettingCount);
    $display("settings included zero and full-scale gains, zero and full-scale duty limits");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
